### rtl/core/rtmpchp_pkg.sv
// Package for the RTMP chunk header parser: constants, result type and helpers.
package rtmpchp_pkg;

  localparam logic [31:0] EXT_MARK     = 32'h00FF_FFFF;
  localparam logic [16:0] CHAN_OFFSET  = 17'd64;
  localparam logic [4:0]  EXT_BYTES    = 5'd4;

  // chunk formats
  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_SIZE  = 2'd1;
  localparam logic [1:0] FMT_DELTA = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // basic header stream id escapes
  localparam logic [5:0] ID_ONE_BYTE = 6'd0;
  localparam logic [5:0] ID_TWO_BYTE = 6'd1;

  // message header byte offsets
  localparam logic [4:0] MSG_TIME_END = 5'd3;
  localparam logic [4:0] MSG_LEN_END  = 5'd6;
  localparam logic [4:0] MSG_TYPE     = 5'd6;
  localparam logic [4:0] MSG_STREAM0  = 5'd7;
  localparam logic [4:0] MSG_STREAM1  = 5'd8;
  localparam logic [4:0] MSG_STREAM2  = 5'd9;
  localparam logic [4:0] MSG_STREAM3  = 5'd10;

  typedef struct packed {
    logic [1:0]  frame_format;
    logic [16:0] channel_id;
    logic [31:0] time_value;
    logic [23:0] payload_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream;
    logic        extended_time;
    logic [4:0]  header_length;
  } res_t;

  function automatic logic [3:0] msg_len(input logic [1:0] fmt);
    logic [3:0] len;
    unique case (fmt)
      FMT_FULL:  len = 4'd11;
      FMT_SIZE:  len = 4'd7;
      FMT_DELTA: len = 4'd3;
      default:   len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/rtmp_chunk_header_parser.sv
// Top level of the RTMP chunk header parser.
// Takes one byte per cycle while in_stall is low; the header state is updated by one
// pass of byte-wide logic per item, and the result for the byte that completes the
// header is registered into the output register, or into a one-entry skid buffer when
// the output is stalled; the input only stalls when both hold unread results.
module rtmp_chunk_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_header_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_format,
  output logic [16:0] out_channel_id,
  output logic [31:0] out_time_value,
  output logic [23:0] out_payload_length,
  output logic [7:0]  out_message_type,
  output logic [31:0] out_message_stream,
  output logic        out_extended_time,
  output logic [4:0]  out_header_length
);

  logic        active_r, active_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [1:0]  basic_r, basic_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [16:0] chan_r, chan_nxt;
  logic [31:0] time_r, time_nxt;
  logic [23:0] len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] stream_r, stream_nxt;
  logic        ext_r, ext_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  rtmpchp_pkg::res_t out_r, out_nxt, skid_r, skid_nxt, res;

  logic        accept, emit, step;
  logic [5:0]  id;
  logic [4:0]  m_off, total;
  logic [3:0]  ml;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;
  assign id       = in_data_byte[5:0];
  assign m_off    = pos_r - {3'b0, basic_r};

  // header state update for one byte
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    basic_nxt  = basic_r;
    fmt_nxt    = fmt_r;
    chan_nxt   = chan_r;
    time_nxt   = time_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    stream_nxt = stream_r;
    ext_nxt    = ext_r;
    step       = 1'b0;
    if (accept && in_header_start) begin
      step       = 1'b1;
      active_nxt = 1'b1;
      fmt_nxt    = in_data_byte[7:6];
      if (id == rtmpchp_pkg::ID_ONE_BYTE) begin
        basic_nxt = 2'd2;
      end else if (id == rtmpchp_pkg::ID_TWO_BYTE) begin
        basic_nxt = 2'd3;
      end else begin
        basic_nxt = 2'd1;
      end
      chan_nxt   = {11'b0, id};
      time_nxt   = '0;
      len_nxt    = '0;
      type_nxt   = '0;
      stream_nxt = '0;
      ext_nxt    = 1'b0;
      pos_nxt    = 5'd1;
    end else if (accept && active_r) begin
      step = 1'b1;
      if (pos_r < {3'b0, basic_r}) begin
        if (pos_r == 5'd1) begin
          chan_nxt = rtmpchp_pkg::CHAN_OFFSET + {9'b0, in_data_byte};
        end else begin
          chan_nxt = chan_r + {1'b0, in_data_byte, 8'b0};
        end
      end else begin
        // past the message header only the extended timestamp remains
        priority if (m_off >= {1'b0, rtmpchp_pkg::msg_len(fmt_r)}) begin
          time_nxt = {time_r[23:0], in_data_byte};
        end else if (m_off < rtmpchp_pkg::MSG_TIME_END) begin
          time_nxt = {8'b0, time_r[15:0], in_data_byte};
        end else if (m_off < rtmpchp_pkg::MSG_LEN_END) begin
          len_nxt = {len_r[15:0], in_data_byte};
        end else if (m_off == rtmpchp_pkg::MSG_TYPE) begin
          type_nxt = in_data_byte;
        end else if (m_off == rtmpchp_pkg::MSG_STREAM0) begin
          stream_nxt = stream_r | {24'b0, in_data_byte};
        end else if (m_off == rtmpchp_pkg::MSG_STREAM1) begin
          stream_nxt = stream_r | {16'b0, in_data_byte, 8'b0};
        end else if (m_off == rtmpchp_pkg::MSG_STREAM2) begin
          stream_nxt = stream_r | {8'b0, in_data_byte, 16'b0};
        end else if (m_off == rtmpchp_pkg::MSG_STREAM3) begin
          stream_nxt = stream_r | {in_data_byte, 24'b0};
        end else begin
          stream_nxt = stream_r;
        end
      end
      pos_nxt = pos_r + 5'd1;
    end

    ml = rtmpchp_pkg::msg_len(fmt_nxt);
    // escape marker at the end of the message header pulls in four more bytes
    if (step && fmt_nxt != rtmpchp_pkg::FMT_NONE && !ext_nxt &&
        pos_nxt == ({3'b0, basic_nxt} + {1'b0, ml}) && time_nxt == rtmpchp_pkg::EXT_MARK) begin
      ext_nxt  = 1'b1;
      time_nxt = '0;
    end
    total = {3'b0, basic_nxt} + {1'b0, ml} + (ext_nxt ? rtmpchp_pkg::EXT_BYTES : 5'd0);
    emit  = step && (pos_nxt >= total);
    if (emit) begin
      active_nxt = 1'b0;
    end

    res.frame_format   = fmt_nxt;
    res.channel_id     = chan_nxt;
    res.time_value     = time_nxt;
    res.payload_length = len_nxt;
    res.message_type   = type_nxt;
    res.message_stream = stream_nxt;
    res.extended_time  = ext_nxt;
    res.header_length  = total;
  end

  // output register with skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = emit;
      end
    end else if (emit) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    basic_r  <= basic_nxt;
    fmt_r    <= fmt_nxt;
    chan_r   <= chan_nxt;
    time_r   <= time_nxt;
    len_r    <= len_nxt;
    type_r   <= type_nxt;
    stream_r <= stream_nxt;
    ext_r    <= ext_nxt;
    out_r    <= out_nxt;
    skid_r   <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_format   = out_r.frame_format;
  assign out_channel_id     = out_r.channel_id;
  assign out_time_value     = out_r.time_value;
  assign out_payload_length = out_r.payload_length;
  assign out_message_type   = out_r.message_type;
  assign out_message_stream = out_r.message_stream;
  assign out_extended_time  = out_r.extended_time;
  assign out_header_length  = out_r.header_length;

endmodule

### tb/sv/tb_top.sv
// Testbench for the RTMP chunk header parser: header predictor, byte sender and result checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int FULL_HEADER = 32;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_header_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_format;
  logic [16:0] out_channel_id;
  logic [31:0] out_time_value;
  logic [23:0] out_payload_length;
  logic [7:0]  out_message_type;
  logic [31:0] out_message_stream;
  logic        out_extended_time;
  logic [4:0]  out_header_length;

  // predicted parser state
  logic        hdr_busy = 1'b0;
  logic [4:0]  hdr_pos = 5'd0;
  logic [1:0]  id_len = 2'd1;
  logic [1:0]  hdr_fmt = rtmpchp_pkg::FMT_FULL;
  logic [16:0] chan_sum = '0;
  logic [31:0] time_sum = '0;
  logic [23:0] len_sum = '0;
  logic [7:0]  type_val = '0;
  logic [31:0] stream_sum = '0;
  logic        ext_seen = 1'b0;

  rtmpchp_pkg::res_t expected_headers[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_used = 0;
  int headers_checked = 0;
  int ext_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  rtmp_chunk_header_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_header_start    (in_header_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_format   (out_frame_format),
    .out_channel_id     (out_channel_id),
    .out_time_value     (out_time_value),
    .out_payload_length (out_payload_length),
    .out_message_type   (out_message_type),
    .out_message_stream (out_message_stream),
    .out_extended_time  (out_extended_time),
    .out_header_length  (out_header_length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [4:0] body_bytes(input logic [1:0] fmt);
    case (fmt)
      rtmpchp_pkg::FMT_FULL:  return 5'd11;
      rtmpchp_pkg::FMT_SIZE:  return 5'd7;
      rtmpchp_pkg::FMT_DELTA: return 5'd3;
      default:                return 5'd0;
    endcase
  endfunction

  // Advance the predicted header state by one accepted byte; queue a header when complete.
  task automatic parse_byte(input logic [7:0] b, input logic s);
    logic [4:0] m;
    logic [4:0] ml;
    logic [4:0] total;
    rtmpchp_pkg::res_t hdr;
    if (s) begin
      hdr_busy = 1'b1;
      hdr_fmt = b[7:6];
      id_len = (b[5:0] == rtmpchp_pkg::ID_ONE_BYTE) ? 2'd2 :
               (b[5:0] == rtmpchp_pkg::ID_TWO_BYTE) ? 2'd3 : 2'd1;
      chan_sum = {11'd0, b[5:0]};
      time_sum = '0;
      len_sum = '0;
      type_val = '0;
      stream_sum = '0;
      ext_seen = 1'b0;
      hdr_pos = 5'd1;
    end else if (hdr_busy) begin
      if (hdr_pos < id_len) begin
        if (hdr_pos == 5'd1)
          chan_sum = rtmpchp_pkg::CHAN_OFFSET + {9'd0, b};
        else
          chan_sum = chan_sum + {1'b0, b, 8'h00};
      end else begin
        m = hdr_pos - id_len;
        ml = body_bytes(hdr_fmt);
        // bytes past the message header are the big-endian extended timestamp
        if (m >= ml)
          time_sum = {time_sum[23:0], b};
        else if (m < rtmpchp_pkg::MSG_TIME_END)
          time_sum = {8'h00, time_sum[15:0], b};
        else if (m < rtmpchp_pkg::MSG_LEN_END)
          len_sum = {len_sum[15:0], b};
        else if (m == rtmpchp_pkg::MSG_TYPE)
          type_val = b;
        else
          stream_sum = stream_sum |
                       ({24'd0, b} << (8 * (m - rtmpchp_pkg::MSG_STREAM0)));
      end
      hdr_pos = hdr_pos + 5'd1;
    end
    if (s || hdr_busy) begin
      ml = body_bytes(hdr_fmt);
      if (hdr_fmt != rtmpchp_pkg::FMT_NONE && !ext_seen && hdr_pos == id_len + ml &&
          time_sum == rtmpchp_pkg::EXT_MARK) begin
        ext_seen = 1'b1;
        time_sum = '0;
      end
      total = id_len + ml + (ext_seen ? rtmpchp_pkg::EXT_BYTES : 5'd0);
      if (hdr_pos >= total) begin
        hdr.frame_format = hdr_fmt;
        hdr.channel_id = chan_sum;
        hdr.time_value = time_sum;
        hdr.payload_length = len_sum;
        hdr.message_type = type_val;
        hdr.message_stream = stream_sum;
        hdr.extended_time = ext_seen;
        hdr.header_length = total;
        expected_headers.push_back(hdr);
        hdr_busy = 1'b0;
      end
    end
  endtask

  // Called and returns at a falling edge; in_valid stays high between back-to-back items.
  task automatic send_byte(input logic [7:0] b, input logic s);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_header_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s || hdr_busy) bytes_used++;
    parse_byte(b, s);
    @(negedge clk);
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    int pick;
    pick = $urandom_range(9);
    if (fill == FILL_ZERO) return 8'h00;
    if (fill == FILL_ONES) return 8'hFF;
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Build one chunk header and send its first cut bytes.
  task automatic send_header(input logic [1:0] fmt, input logic [5:0] id6, input int fill,
                             input logic force_ext, input int cut);
    logic [7:0] seq[$];
    logic [23:0] ts;
    int ml;
    seq.push_back({fmt, id6});
    if (id6 == rtmpchp_pkg::ID_ONE_BYTE) begin
      seq.push_back(fill_byte(fill));
    end else if (id6 == rtmpchp_pkg::ID_TWO_BYTE) begin
      seq.push_back(fill_byte(fill));
      seq.push_back(fill_byte(fill));
    end
    ml = body_bytes(fmt);
    ts = force_ext ? rtmpchp_pkg::EXT_MARK[23:0] :
                     {fill_byte(fill), fill_byte(fill), fill_byte(fill)};
    for (int i = 0; i < ml; i++) begin
      if (i < 3)
        seq.push_back(8'(ts >> (16 - 8 * i)));
      else
        seq.push_back(fill_byte(fill));
    end
    if (ml != 0 && ts == rtmpchp_pkg::EXT_MARK[23:0])
      repeat (4) seq.push_back(fill_byte(fill));
    for (int i = 0; i < seq.size() && i < cut; i++)
      send_byte(seq[i], i == 0);
  endtask

  task automatic wait_for_results();
    while (expected_headers.size() != 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [5:0] pick_stream_id();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1:    return rtmpchp_pkg::ID_ONE_BYTE;
      2, 3:    return rtmpchp_pkg::ID_TWO_BYTE;
      4:       return 6'd2;
      5:       return 6'd63;
      default: return 6'($urandom_range(63, 2));
    endcase
  endfunction

  task automatic run_phase(input int idle, input int stall, input int target);
    int first;
    int pick;
    logic paused;
    idle_pct = idle;
    stall_pct = stall;
    first = bytes_used;
    paused = 1'b0;
    while (bytes_used - first < target) begin
      pick = $urandom_range(99);
      if (pick < 78)
        send_header(2'($urandom_range(3)), pick_stream_id(), FILL_RANDOM,
                    $urandom_range(4) == 0, FULL_HEADER);
      else if (pick < 90)
        send_header(2'($urandom_range(3)), pick_stream_id(), FILL_RANDOM,
                    $urandom_range(3) == 0, $urandom_range(17, 1));
      else
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0);
      if (!paused && bytes_used - first >= target / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_single_byte_headers();
    send_header(rtmpchp_pkg::FMT_NONE, 6'd2, FILL_RANDOM, 1'b0, FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_NONE, 6'd63, FILL_RANDOM, 1'b0, FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_NONE, rtmpchp_pkg::ID_ONE_BYTE, FILL_ZERO, 1'b0,
                FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_NONE, rtmpchp_pkg::ID_ONE_BYTE, FILL_ONES, 1'b0,
                FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_NONE, rtmpchp_pkg::ID_TWO_BYTE, FILL_ONES, 1'b0,
                FULL_HEADER);
  endtask

  task automatic test_each_format();
    send_header(rtmpchp_pkg::FMT_FULL, 6'd2, FILL_ZERO, 1'b0, FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_SIZE, 6'd63, FILL_RANDOM, 1'b0, FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_DELTA, rtmpchp_pkg::ID_TWO_BYTE, FILL_RANDOM, 1'b0,
                FULL_HEADER);
    // all ones: escaped time, widest stream id and every field at its top value
    send_header(rtmpchp_pkg::FMT_FULL, rtmpchp_pkg::ID_TWO_BYTE, FILL_ONES, 1'b0,
                FULL_HEADER);
  endtask

  task automatic test_extended_time();
    send_header(rtmpchp_pkg::FMT_SIZE, 6'd9, FILL_RANDOM, 1'b1, FULL_HEADER);
    send_header(rtmpchp_pkg::FMT_DELTA, rtmpchp_pkg::ID_ONE_BYTE, FILL_RANDOM, 1'b1,
                FULL_HEADER);
    // format 3 never reads an extended timestamp
    send_header(rtmpchp_pkg::FMT_NONE, 6'd40, FILL_ONES, 1'b1, FULL_HEADER);
  endtask

  task automatic test_restart_and_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_header(rtmpchp_pkg::FMT_FULL, 6'd3, FILL_RANDOM, 1'b0, 5);
    send_header(rtmpchp_pkg::FMT_DELTA, 6'd5, FILL_RANDOM, 1'b1, 6);
    send_header(rtmpchp_pkg::FMT_SIZE, 6'd17, FILL_RANDOM, 1'b0, FULL_HEADER);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 250);
    run_phase(70, 0, 250);
    run_phase(0, 70, 250);
    run_phase(8, 8, 250);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rtmpchp_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_headers.size() == 0) begin
        $error("header result with none pending");
        mismatches++;
      end else begin
        want = expected_headers.pop_front();
        check_field("frame_format", 32'(want.frame_format), 32'(out_frame_format));
        check_field("channel_id", 32'(want.channel_id), 32'(out_channel_id));
        check_field("time_value", want.time_value, out_time_value);
        check_field("payload_length", 32'(want.payload_length), 32'(out_payload_length));
        check_field("message_type", 32'(want.message_type), 32'(out_message_type));
        check_field("message_stream", want.message_stream, out_message_stream);
        check_field("extended_time", 32'(want.extended_time), 32'(out_extended_time));
        check_field("header_length", 32'(want.header_length), 32'(out_header_length));
        if (want.extended_time) ext_checked++;
      end
      headers_checked++;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_byte_headers();
    test_each_format();
    test_extended_time();
    test_restart_and_idle_bytes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Parsed %0d header bytes into %0d headers, %0d of them with extended time.",
             bytes_used, headers_checked, ext_checked);
    $display("Covered all formats, 1- to 3-byte stream ids, restarts and idle/stall mixes.");
    if (mismatches == 0 && expected_headers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
